@@ rtl/core/mpfp_pkg.sv @@
// ---------------------------------------------------------------------------
// mpfp_pkg
// Types and constants shared by the mesh packet frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package mpfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int ROLE_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ROUTE_W   = 2;
    localparam int PTYPE_W   = 4;
    localparam int PVER_W    = 2;
    localparam int HWIDTH_W  = 3;
    localparam int HCOUNT_W  = 6;

    // parse phase, one-hot
    typedef enum logic [5:0] {
        PH_HEADER    = 6'b000001,
        PH_TRANSPORT = 6'b000010,
        PH_PATHLEN   = 6'b000100,
        PH_PATH      = 6'b001000,
        PH_PAYLOAD   = 6'b010000,
        PH_IGNORE    = 6'b100000
    } t_phase;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_HEADER    = 3'd0,
        ROLE_TRANSPORT = 3'd1,
        ROLE_PATHLEN   = 3'd2,
        ROLE_PATH      = 3'd3,
        ROLE_PAYLOAD   = 3'd4,
        ROLE_IGNORED   = 3'd5
    } t_role;

    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD    = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_BADPATH = 2'd2,
        ST_TOOLONG = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PATH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd3;

    localparam logic [ROUTE_W-1:0] RST_FLOOD_CODE  = 2'd0;
    localparam logic [ROUTE_W-1:0] RST_DIRECT_CODE = 2'd3;
    localparam logic [BYTE_W-1:0]  RST_MAX_PATH    = 8'd64;
    localparam logic [BYTE_W-1:0]  RST_MAX_PAYLOAD = 8'd184;

    localparam logic [BYTE_W-1:0] TRANSPORT_BYTES = 8'd4;
    localparam logic [BYTE_W-1:0] COUNT_MAX       = 8'hFF;
    localparam logic [1:0]        HASH_SEL_BAD    = 2'b11;

    // path byte length from a path-length byte: entries * (size field + 1)
    function automatic logic [BYTE_W-1:0] path_bytes(input logic [BYTE_W-1:0] plen);
        logic [BYTE_W-1:0] w;
        logic [BYTE_W-1:0] n;
        w = BYTE_W'(plen[7:6]) + 8'd1;
        n = BYTE_W'(plen[5:0]);
        return BYTE_W'(n * w);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mesh_packet_frame_parser_core.sv @@
// A byte's result word is loaded into the output register at the edge that accepts the byte.
// Throughput: one byte per cycle while i_ready is high; the output register refills while it is read.
// Timing is set by the phase update and the 6x3 path length product.
// Reset (synchronous, active low) clears the parse state, empties the output
// register and loads the configuration registers with their defaults.
// ---------------------------------------------------------------------------
// mesh_packet_frame_parser_core
// Byte-serial mesh radio frame parser with role tagging and frame status.
// ---------------------------------------------------------------------------
`default_nettype none

module mesh_packet_frame_parser_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [mpfp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [mpfp_pkg::BYTE_W-1:0]         i_cfg_data,
    // input byte channel
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [mpfp_pkg::BYTE_W-1:0]         i_rx_byte,
    input  wire                                 i_end_of_frame,
    // result channel
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [mpfp_pkg::BYTE_W-1:0]         o_byte_value,
    output logic [mpfp_pkg::ROLE_W-1:0]         o_byte_role,
    output logic [mpfp_pkg::ROUTE_W-1:0]        o_route_kind,
    output logic [mpfp_pkg::PTYPE_W-1:0]        o_payload_kind,
    output logic [mpfp_pkg::PVER_W-1:0]         o_payload_version,
    output logic [mpfp_pkg::HWIDTH_W-1:0]       o_hash_width,
    output logic [mpfp_pkg::HCOUNT_W-1:0]       o_hash_entries,
    output logic                                o_frame_done,
    output logic [mpfp_pkg::STATUS_W-1:0]       o_frame_status
);
    import mpfp_pkg::*;

    // configuration
    logic [ROUTE_W-1:0] r_flood_code;
    logic [ROUTE_W-1:0] r_direct_code;
    logic [BYTE_W-1:0]  r_max_path;
    logic [BYTE_W-1:0]  r_max_payload;

    // parse state
    t_phase            r_phase,   n_phase;
    logic [BYTE_W-1:0] r_field,   n_field;
    logic [BYTE_W-1:0] r_header,  n_header;
    logic [BYTE_W-1:0] r_plen,    n_plen;
    logic [BYTE_W-1:0] r_pay,     n_pay;
    t_status           r_err,     n_err;

    // result register
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    t_role               r_out_role;
    logic [BYTE_W-1:0]   r_out_header;
    logic [BYTE_W-1:0]   r_out_plen;
    logic                r_out_done;
    t_status             r_out_status;

    t_role               role;
    t_status             status;
    logic                in_acc;
    logic [ROUTE_W-1:0]  route;
    logic [BYTE_W-1:0]   new_path_n;
    logic [BYTE_W-1:0]   held_path_n;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign in_acc      = i_valid && o_ready;

    assign route       = i_rx_byte[ROUTE_W-1:0];
    assign new_path_n  = path_bytes(i_rx_byte);
    assign held_path_n = path_bytes(r_plen);

    always_comb begin
        n_phase  = r_phase;
        n_field  = r_field;
        n_header = r_header;
        n_plen   = r_plen;
        n_pay    = r_pay;
        n_err    = r_err;
        role     = ROLE_IGNORED;
        status   = ST_GOOD;

        case (r_phase)
            PH_HEADER: begin
                role     = ROLE_HEADER;
                n_header = i_rx_byte;
                n_field  = '0;
                if (route == r_flood_code || route == r_direct_code) begin
                    n_phase = PH_TRANSPORT;
                end else begin
                    n_phase = PH_PATHLEN;
                end
            end
            PH_TRANSPORT: begin
                role    = ROLE_TRANSPORT;
                n_field = r_field + 8'd1;
                if (n_field >= TRANSPORT_BYTES) begin
                    n_field = '0;
                    n_phase = PH_PATHLEN;
                end
            end
            PH_PATHLEN: begin
                role    = ROLE_PATHLEN;
                n_plen  = i_rx_byte;
                n_field = '0;
                if (i_rx_byte[7:6] == HASH_SEL_BAD || new_path_n > r_max_path) begin
                    n_err   = ST_BADPATH;
                    n_phase = PH_IGNORE;
                end else if (new_path_n == '0) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_PATH;
                end
            end
            PH_PATH: begin
                role    = ROLE_PATH;
                n_field = r_field + 8'd1;
                if (n_field >= held_path_n) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                role = ROLE_PAYLOAD;
                if (r_pay >= r_max_payload) begin
                    n_err   = ST_TOOLONG;
                    n_phase = PH_IGNORE;
                end
                // saturate on overlong frames
                if (r_pay != COUNT_MAX) begin
                    n_pay = r_pay + 8'd1;
                end
            end
            default: begin
                role    = ROLE_IGNORED;
                n_phase = PH_IGNORE;
            end
        endcase

        if (i_end_of_frame) begin
            if (n_err != ST_GOOD) begin
                status = n_err;
            end else if (!(n_phase == PH_PAYLOAD && n_pay != '0)) begin
                status = ST_TRUNC;
            end else begin
                status = ST_GOOD;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flood_code  <= RST_FLOOD_CODE;
            r_direct_code <= RST_DIRECT_CODE;
            r_max_path    <= RST_MAX_PATH;
            r_max_payload <= RST_MAX_PAYLOAD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FLOOD_CODE:  r_flood_code  <= i_cfg_data[ROUTE_W-1:0];
                CFG_DIRECT_CODE: r_direct_code <= i_cfg_data[ROUTE_W-1:0];
                CFG_MAX_PATH:    r_max_path    <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // parse state: drop back to header on the last word of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_field  <= '0;
            r_header <= '0;
            r_plen   <= '0;
            r_pay    <= '0;
            r_err    <= ST_GOOD;
        end else if (in_acc) begin
            if (i_end_of_frame) begin
                r_phase  <= PH_HEADER;
                r_field  <= '0;
                r_header <= '0;
                r_plen   <= '0;
                r_pay    <= '0;
                r_err    <= ST_GOOD;
            end else begin
                r_phase  <= n_phase;
                r_field  <= n_field;
                r_header <= n_header;
                r_plen   <= n_plen;
                r_pay    <= n_pay;
                r_err    <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload: header and path fields as updated by this word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_byte   <= i_rx_byte;
            r_out_role   <= role;
            r_out_header <= n_header;
            r_out_plen   <= n_plen;
            r_out_done   <= i_end_of_frame;
            r_out_status <= status;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_byte_value      = r_out_byte;
    assign o_byte_role       = r_out_role;
    assign o_route_kind      = r_out_header[1:0];
    assign o_payload_kind    = r_out_header[5:2];
    assign o_payload_version = r_out_header[7:6];
    assign o_hash_width      = HWIDTH_W'(r_out_plen[7:6]) + 3'd1;
    assign o_hash_entries    = r_out_plen[5:0];
    assign o_frame_done      = r_out_done;
    assign o_frame_status    = r_out_status;

`ifndef SYNTH
    a_eof_returns_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_frame) |=> (r_phase == PH_HEADER && r_err == ST_GOOD))
        else $error("parser not back at header after frame end");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_done) |-> (o_frame_status == ST_GOOD))
        else $error("frame status set on a word that does not end the frame");

    a_error_implies_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_GOOD) |-> (r_phase == PH_IGNORE))
        else $error("sticky error held outside the ignore phase");

    a_ignored_role_needs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_IGNORE) |=> (o_byte_role == ROLE_IGNORED))
        else $error("word after error not marked ignored");
`endif

endmodule

`default_nettype wire
